@@ sv/afv_pkg.sv @@
package afv_pkg;

  localparam int RAD_W  = 20;
  localparam int SEG_W  = 7;
  localparam int DEG_W  = 11;
  localparam int ROT_W  = 18;
  localparam int POS_W  = 24;
  localparam int TEX_W  = 17;
  localparam int TRIG_W = 18;
  localparam int ANG_W  = 28;
  localparam int XY_W   = 33;
  localparam int DIVD_W = 27;
  localparam int ATAN_IDX_W = 5;
  localparam int IN_W   = 168;
  localparam int OUT_W  = 88;

  localparam logic [SEG_W-1:0] MIN_SEGMENTS = 7'd3;

  localparam logic signed [ANG_W-1:0] ANG_FULL    = 28'sd23592960;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 28'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 28'sd5898240;
  localparam logic signed [XY_W-1:0]  CORDIC_X0   = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE   = 18'sd65536;
  localparam logic [TEX_W-1:0] TEX_HALF = 17'd32768;

  typedef enum logic [1:0] {
    CP_IDLE, CP_WRAP, CP_ITER, CP_FIN
  } cordic_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BAD, ST_DIV, ST_RGO, ST_RWAIT, ST_TGO, ST_TWAIT,
    ST_MR1, ST_MR2, ST_MR3, ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_LOAD
  } afv_state_t;

  function automatic logic [21:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/afv_div.sv @@
module afv_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [afv_pkg::DIVD_W-1:0] dividend,
  input  logic [afv_pkg::SEG_W-1:0]  divisor,
  output logic                       done,
  output logic [afv_pkg::DIVD_W-1:0] quotient
);
  import afv_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SEG_W-1:0] rem;
  logic [SEG_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? SEG_W'(rem_sh - {1'b0, divisor}) : SEG_W'(rem_sh);
      quotient <= {quotient[DIVD_W-2:0], fits};
    end
  end

endmodule

@@ sv/afv_cordic.sv @@
module afv_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [afv_pkg::ANG_W-1:0]  angle,
  output logic                              done,
  output logic signed [afv_pkg::TRIG_W-1:0] cos_q,
  output logic signed [afv_pkg::TRIG_W-1:0] sin_q
);
  import afv_pkg::*;

  localparam int CNT_W = $clog2(STEPS + 1);

  cordic_phase_t phase, phase_next;

  logic signed [ANG_W-1:0]  z;
  logic signed [XY_W-1:0]   x, y, dx, dy, xr, yr;
  logic signed [ANG_W-1:0]  atan_v;
  logic signed [TRIG_W-1:0] xc, yc;
  logic                     neg;
  logic [CNT_W-1:0]         cnt;
  logic                     in_range;

  assign in_range = (z <= ANG_HALF) && (z > -ANG_HALF);
  assign dx       = y >>> cnt;
  assign dy       = x >>> cnt;
  assign atan_v   = signed'(ANG_W'(atan_q16(ATAN_IDX_W'(cnt))));
  assign xr       = (x + XY_W'(8192)) >>> 14;
  assign yr       = (y + XY_W'(8192)) >>> 14;

  always_comb begin
    if (xr > XY_W'(TRIG_ONE)) xc = TRIG_ONE;
    else if (xr < -XY_W'(TRIG_ONE)) xc = -TRIG_ONE;
    else xc = TRIG_W'(xr);
    if (yr > XY_W'(TRIG_ONE)) yc = TRIG_ONE;
    else if (yr < -XY_W'(TRIG_ONE)) yc = -TRIG_ONE;
    else yc = TRIG_W'(yr);
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= CP_IDLE;
    else phase <= phase_next;
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      CP_IDLE: if (start) phase_next = CP_WRAP;
      CP_WRAP: if (in_range) phase_next = CP_ITER;
      CP_ITER: if (cnt == CNT_W'(STEPS - 1)) phase_next = CP_FIN;
      CP_FIN:  phase_next = CP_IDLE;
      default: phase_next = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (phase == CP_FIN);
  end

  always_ff @(posedge clk) begin
    case (phase)
      CP_IDLE: begin
        z   <= angle;
        x   <= CORDIC_X0;
        y   <= '0;
        cnt <= '0;
      end
      CP_WRAP: begin
        if (z > ANG_HALF) begin
          z <= z - ANG_FULL;
        end else if (z <= -ANG_HALF) begin
          z <= z + ANG_FULL;
        end else if (z > ANG_QUARTER) begin
          z   <= z - ANG_HALF;
          neg <= 1'b1;
        end else if (z < -ANG_QUARTER) begin
          z   <= z + ANG_HALF;
          neg <= 1'b1;
        end else begin
          neg <= 1'b0;
        end
      end
      CP_ITER: begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_v;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_v;
        end
        cnt <= cnt + CNT_W'(1);
      end
      CP_FIN: begin
        cos_q <= neg ? -xc : xc;
        sin_q <= neg ? -yc : yc;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/arc_fan_vertex_generator.sv @@
// Arc fan vertex generator. Each input transaction requests one triangle-fan arc and yields
// segments+2 output transactions: the fan center (uv 0.5,0.5) and then segments+1 rim points,
// each translated by -pivot, rotated, and offset by the placement, in saturated Q16.8. A zero
// radius or a segment count outside 3..MAX_SEGMENTS yields one transaction with tuser set.
// s_tready is high only between requests. One request runs the step divider and a CORDIC
// rotation for the rotation angle, then a CORDIC run and the scaling multiplies for each rim
// point, the center skipping both; the iterative CORDIC unit and the single shared multiplier
// set the time per request.
module arc_fan_vertex_generator #(
  parameter int MAX_SEGMENTS = 62,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // radius, segments, start_deg, end_deg, rotation_deg, pivot_x, pivot_y, place_x, place_y
  input  logic [afv_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // pos_x, pos_y, tex_u, tex_v
  output logic [afv_pkg::OUT_W-1:0]    m_tdata,
  // bad_request
  output logic                         m_tuser,
  // last_vertex
  output logic                         m_tlast
);
  import afv_pkg::*;

  localparam int VIDX_W = $clog2(MAX_SEGMENTS + 2);

  afv_state_t state, state_next;

  logic [RAD_W-1:0]         radius;
  logic [SEG_W-1:0]         segs;
  logic signed [ROT_W-1:0]  rot;
  logic signed [POS_W-1:0]  pivot_x, pivot_y, place_x, place_y;
  logic signed [ANG_W-1:0]  accum, step;
  logic signed [TRIG_W-1:0] rot_cos, rot_sin;
  logic [VIDX_W-1:0]        vidx;
  logic signed [21:0]       px, py;
  logic [TEX_W-1:0]         tu, tv;
  logic signed [25:0]       mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [43:0]       prod;
  logic signed [44:0]       accx, accy;
  logic signed [24:0]       dx, dy;
  logic signed [29:0]       rx, ry;
  logic signed [POS_W-1:0]  sx, sy;
  logic signed [TRIG_W:0]   csum, ssum;
  logic signed [DEG_W:0]    diff;
  logic [DIVD_W-1:0]        dividend, quotient;
  logic                     diff_neg, step_neg, div_start, div_done;
  logic                     cor_start, cor_done;
  logic signed [ANG_W-1:0]  cor_angle;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;
  logic                     accept, bad, out_free, last;

  logic [RAD_W-1:0]        in_radius;
  logic [SEG_W-1:0]        in_segs;
  logic signed [DEG_W-1:0] in_start, in_end;

  assign in_radius = s_tdata[19:0];
  assign in_segs   = s_tdata[26:20];
  assign in_start  = s_tdata[37:27];
  assign in_end    = s_tdata[48:38];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign bad      = (in_radius == '0) || (in_segs < MIN_SEGMENTS) ||
                    (in_segs > SEG_W'(MAX_SEGMENTS));
  assign out_free = !m_tvalid || m_tready;
  assign last     = ((SEG_W+1)'(vidx)) == ({1'b0, segs} + (SEG_W+1)'(1));

  assign diff      = (DEG_W+1)'(in_end) - (DEG_W+1)'(in_start);
  assign diff_neg  = diff[DEG_W];
  assign dividend  = {DEG_W'(diff_neg ? -diff : diff), 16'b0};
  assign div_start = accept && !bad;

  assign cor_start = (state == ST_RGO) || (state == ST_TGO);
  assign cor_angle = (state == ST_RGO) ? {{2{rot[ROT_W-1]}}, rot, 8'b0} : accum;

  assign dx   = 25'(px) - 25'(pivot_x);
  assign dy   = 25'(py) - 25'(pivot_y);
  assign csum = (TRIG_W+1)'(cor_cos) + (TRIG_W+1)'(65537);
  assign ssum = (TRIG_W+1)'(cor_sin) + (TRIG_W+1)'(65537);
  assign rx   = 30'((accx + 45'sd32768) >>> 16) + 30'(place_x);
  assign ry   = 30'((accy + 45'sd32768) >>> 16) + 30'(place_y);

  always_comb begin
    if (rx > 30'sd8388607) sx = 24'sh7FFFFF;
    else if (rx < -30'sd8388608) sx = 24'sh800000;
    else sx = POS_W'(rx);
    if (ry > 30'sd8388607) sy = 24'sh7FFFFF;
    else if (ry < -30'sd8388608) sy = 24'sh800000;
    else sy = POS_W'(ry);
  end

  always_comb begin
    case (state)
      ST_MR1: begin mul_a = signed'(26'(radius)); mul_b = cor_cos; end
      ST_MR2: begin mul_a = signed'(26'(radius)); mul_b = cor_sin; end
      ST_X2:  begin mul_a = 26'(dy); mul_b = rot_sin; end
      ST_X3:  begin mul_a = 26'(dx); mul_b = rot_sin; end
      ST_X4:  begin mul_a = 26'(dy); mul_b = rot_cos; end
      default: begin mul_a = 26'(dx); mul_b = rot_cos; end
    endcase
  end

  afv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (segs),
    .done     (div_done),
    .quotient (quotient)
  );

  afv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = bad ? ST_BAD : ST_DIV;
      ST_BAD:   if (out_free) state_next = ST_IDLE;
      ST_DIV:   if (div_done) state_next = ST_RGO;
      ST_RGO:   state_next = ST_RWAIT;
      ST_RWAIT: if (cor_done) state_next = ST_X1;
      ST_TGO:   state_next = ST_TWAIT;
      ST_TWAIT: if (cor_done) state_next = ST_MR1;
      ST_MR1:   state_next = ST_MR2;
      ST_MR2:   state_next = ST_MR3;
      ST_MR3:   state_next = ST_X1;
      ST_X1:    state_next = ST_X2;
      ST_X2:    state_next = ST_X3;
      ST_X3:    state_next = ST_X4;
      ST_X4:    state_next = ST_X5;
      ST_X5:    state_next = ST_LOAD;
      ST_LOAD:  if (out_free) state_next = last ? ST_IDLE : ST_TGO;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if ((state == ST_BAD || state == ST_LOAD) && out_free) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        radius   <= in_radius;
        segs     <= in_segs;
        rot      <= s_tdata[66:49];
        pivot_x  <= s_tdata[90:67];
        pivot_y  <= s_tdata[114:91];
        place_x  <= s_tdata[138:115];
        place_y  <= s_tdata[162:139];
        accum    <= {in_start[DEG_W-1], in_start, 16'b0};
        step_neg <= diff_neg;
      end
      ST_BAD: if (out_free) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
        m_tlast <= 1'b1;
      end
      ST_DIV: if (div_done)
        step <= step_neg ? -signed'(ANG_W'(quotient)) : signed'(ANG_W'(quotient));
      ST_RWAIT: if (cor_done) begin
        rot_cos <= cor_cos;
        rot_sin <= cor_sin;
        vidx    <= '0;
        px      <= '0;
        py      <= '0;
        tu      <= TEX_HALF;
        tv      <= TEX_HALF;
      end
      ST_TWAIT: if (cor_done) begin
        tu <= csum[TEX_W:1];
        tv <= ssum[TEX_W:1];
      end
      ST_MR2: px <= 22'((prod + 44'sd32768) >>> 16);
      ST_MR3: py <= 22'((prod + 44'sd32768) >>> 16);
      ST_X2:  accx <= 45'(prod);
      ST_X3:  accx <= accx - 45'(prod);
      ST_X4:  accy <= 45'(prod);
      ST_X5:  accy <= accy + 45'(prod);
      ST_LOAD: if (out_free) begin
        m_tdata <= {6'b0, tv, tu, sy, sx};
        m_tuser <= 1'b0;
        m_tlast <= last;
        vidx    <= vidx + VIDX_W'(1);
        if (vidx != '0) accum <= accum + step;
      end
      default: ;
    endcase
  end

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("rejected request result not final or not zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready high right after a request was taken");

  a_vidx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> (SEG_W+1)'(vidx) <= ({1'b0, segs} + (SEG_W+1)'(1)))
    else $error("vertex index beyond the rim");

  a_cordic_done_wait: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == ST_RWAIT || state == ST_TWAIT)
    else $error("trig result arrived outside a wait state");

endmodule

@@ bench/arc_fan_vertex_generator_test.sv @@
`timescale 1ns / 100ps

module arc_fan_vertex_generator_test;
  import afv_pkg::*;

  localparam int MAX_SEG = 62;
  localparam int CSTEPS = 16;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic signed [23:0] place_y;
    logic signed [23:0] place_x;
    logic signed [23:0] pivot_y;
    logic signed [23:0] pivot_x;
    logic signed [17:0] rotation_deg;
    logic signed [10:0] end_deg;
    logic signed [10:0] start_deg;
    logic [6:0]         segments;
    logic [19:0]        radius;
  } arc_req_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic [16:0]        tex_v;
    logic [16:0]        tex_u;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_x;
  } vtx_data_t;

  typedef struct {
    vtx_data_t d;
    logic      bad;
    logic      last;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  arc_fan_vertex_generator #(.MAX_SEGMENTS(MAX_SEG), .CORDIC_STEPS(CSTEPS)) u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  arc_req_t pending_reqs[$];
  vertex_t  expected_vertices[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 0;
  int errors = 0;
  int reqs_sent = 0;
  int vertices_seen = 0;
  int bad_seen = 0;
  int idle_cycles = 0;

  function automatic longint fshift(longint v, int n);
    if (v >= 0) return v >>> n;
    return -((-v + ((longint'(1) << n) - 1)) >>> n);
  endfunction

  function automatic longint rshift(longint v, int n);
    return fshift(v + (longint'(1) << (n - 1)), n);
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sincos(longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit neg;
    r = ang % 23592960;
    x = 652032874;
    y = 0;
    neg = 0;
    if (r > 11796480) r -= 23592960;
    else if (r <= -11796480) r += 23592960;
    if (r > 5898240) begin
      r -= 11796480;
      neg = 1;
    end else if (r < -5898240) begin
      r += 11796480;
      neg = 1;
    end
    z = r;
    for (int i = 0; i < CSTEPS && i < 24; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q16(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q16(i[4:0]));
      end
    end
    x = clampv(rshift(x, 14), -65536, 65536);
    y = clampv(rshift(y, 14), -65536, 65536);
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic vertex_t place_vertex(longint px, longint py, longint u, longint v,
                                           arc_req_t rq, longint rc, longint rs, bit last);
    vertex_t t;
    longint dx, dy, rx, ry;
    dx = px - longint'(rq.pivot_x);
    dy = py - longint'(rq.pivot_y);
    rx = rshift(dx * rc - dy * rs, 16) + longint'(rq.place_x);
    ry = rshift(dx * rs + dy * rc, 16) + longint'(rq.place_y);
    t.d = '0;
    t.d.pos_x = 24'(clampv(rx, -8388608, 8388607));
    t.d.pos_y = 24'(clampv(ry, -8388608, 8388607));
    t.d.tex_u = 17'(u);
    t.d.tex_v = 17'(v);
    t.bad = 0;
    t.last = last;
    return t;
  endfunction

  function automatic void predict_fan(arc_req_t rq);
    vertex_t t;
    longint rc, rs, c, s, step, accum, px, py;
    if (rq.radius == 0 || rq.segments < 3 || rq.segments > MAX_SEG) begin
      t.d = '0;
      t.bad = 1;
      t.last = 1;
      expected_vertices.push_back(t);
      return;
    end
    sincos(longint'(rq.rotation_deg) * 256, rc, rs);
    step = ((longint'(rq.end_deg) - longint'(rq.start_deg)) * 65536) / longint'(rq.segments);
    accum = longint'(rq.start_deg) * 65536;
    expected_vertices.push_back(place_vertex(0, 0, 32768, 32768, rq, rc, rs, 0));
    for (int i = 0; i <= rq.segments; i++) begin
      sincos(accum, c, s);
      px = rshift(longint'(rq.radius) * c, 16);
      py = rshift(longint'(rq.radius) * s, 16);
      expected_vertices.push_back(place_vertex(px, py, (c + 65537) / 2, (s + 65537) / 2,
                                               rq, rc, rs, i == rq.segments));
      accum += step;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_fan(arc_req_t'(s_tdata[162:0]));
        reqs_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_reqs.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct)
        begin
          s_tdata <= IN_W'(pending_reqs.pop_front());
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    vtx_data_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = vtx_data_t'(m_tdata);
        vertices_seen++;
        if (m_tuser) bad_seen++;
        if (expected_vertices.size() == 0) begin
          $error("unexpected vertex pos_x=%0d pos_y=%0d", got.pos_x, got.pos_y);
          errors++;
        end else begin
          want = expected_vertices.pop_front();
          if (got.pos_x !== want.d.pos_x) begin
            $error("pos_x expected %0d actual %0d", want.d.pos_x, got.pos_x); errors++;
          end
          if (got.pos_y !== want.d.pos_y) begin
            $error("pos_y expected %0d actual %0d", want.d.pos_y, got.pos_y); errors++;
          end
          if (got.tex_u !== want.d.tex_u) begin
            $error("tex_u expected %0d actual %0d", want.d.tex_u, got.tex_u); errors++;
          end
          if (got.tex_v !== want.d.tex_v) begin
            $error("tex_v expected %0d actual %0d", want.d.tex_v, got.tex_v); errors++;
          end
          if (m_tuser !== want.bad) begin
            $error("bad_request expected %0d actual %0d", want.bad, m_tuser); errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_vertex expected %0d actual %0d", want.last, m_tlast); errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired with %0d vertices outstanding", expected_vertices.size());
        $display("** arc_fan_vertex_generator: FAILED **");
        $finish;
      end
    end
  end

  function automatic arc_req_t rand_req();
    arc_req_t rq;
    int pick;
    rq.radius = ($urandom_range(3) == 0) ? 20'($urandom()) : 20'($urandom_range(1, 4095));
    pick = $urandom_range(19);
    rq.segments = (pick == 0) ? 7'($urandom_range(0, 127)) :
                  (pick < 4) ? 7'($urandom_range(3, MAX_SEG)) : 7'($urandom_range(3, 8));
    if ($urandom_range(29) == 0) rq.radius = 0;
    rq.start_deg = 11'($urandom_range(1440) - 720);
    rq.end_deg = 11'($urandom_range(1440) - 720);
    rq.rotation_deg = 18'($urandom_range(184320) - 92160);
    rq.pivot_x = 24'($urandom());
    rq.pivot_y = 24'($urandom());
    rq.place_x = 24'($urandom());
    rq.place_y = 24'($urandom());
    if ($urandom_range(1)) begin
      rq.pivot_x = $signed(rq.pivot_x) >>> 8;
      rq.pivot_y = $signed(rq.pivot_y) >>> 8;
      rq.place_x = $signed(rq.place_x) >>> 8;
      rq.place_y = $signed(rq.place_y) >>> 8;
    end
    return rq;
  endfunction

  task automatic drain_fans();
    while (pending_reqs.size() > 0 || s_tvalid || expected_vertices.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    arc_req_t rq;
    repeat (10) @(posedge clk);
    rst <= 0;

    rq = '{radius: 20'd256, segments: 7'd4, start_deg: 11'sd0, end_deg: 11'sd90,
           rotation_deg: 18'sd0, default: '0};
    pending_reqs.push_back(rq);
    rq.radius = 20'hFFFFF; rq.segments = 7'd3; rq.start_deg = -11'sd720;
    rq.end_deg = 11'sd720; rq.rotation_deg = 18'sd92160;
    rq.pivot_x = 24'sh7FFFFF; rq.pivot_y = -24'sh800000;
    rq.place_x = 24'sh7FFFFF; rq.place_y = -24'sh800000;
    pending_reqs.push_back(rq);
    rq.rotation_deg = -18'sd92160; rq.pivot_x = -24'sh800000; rq.pivot_y = 24'sh7FFFFF;
    rq.place_x = -24'sh800000; rq.place_y = 24'sh7FFFFF; rq.segments = 7'd62;
    pending_reqs.push_back(rq);
    rq = '{radius: 20'd1000, segments: 7'd5, start_deg: 11'sd300, end_deg: -11'sd100,
           rotation_deg: 18'sd11520, default: '0};
    pending_reqs.push_back(rq);
    rq.start_deg = 11'sd45; rq.end_deg = 11'sd45;
    pending_reqs.push_back(rq);
    rq.radius = 0;
    pending_reqs.push_back(rq);
    rq.radius = 20'd500;
    rq.segments = 7'd0;   pending_reqs.push_back(rq);
    rq.segments = 7'd2;   pending_reqs.push_back(rq);
    rq.segments = 7'd63;  pending_reqs.push_back(rq);
    rq.segments = 7'd127; pending_reqs.push_back(rq);
    rq.segments = 7'd62; rq.start_deg = -11'sd180; rq.end_deg = 11'sd180;
    rq.rotation_deg = -18'sd1; pending_reqs.push_back(rq);
    rq.segments = 7'd3; rq.start_deg = 11'sd90; rq.end_deg = 11'sd270;
    rq.rotation_deg = 18'sd46080; pending_reqs.push_back(rq);
    drain_fans();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 34; k++) begin
        pending_reqs.push_back(rand_req());
        if (ph == 4 && k == 17) begin
          while (pending_reqs.size() > 0) @(posedge clk);
          hold_send = 1;
          while (s_tvalid || expected_vertices.size() > 0) @(posedge clk);
          hold_send = 0;
        end
      end
      drain_fans();
    end
    repeat (2000) @(posedge clk);
    $display("sent %0d arc requests, checked %0d vertices (%0d rejected requests)",
             reqs_sent, vertices_seen, bad_seen);
    $display("phases: no idling, sparse sender, stalling receiver, mixed idling");
    if (errors == 0 && expected_vertices.size() == 0) begin
      $display("** arc_fan_vertex_generator: PASSED **");
    end else begin
      $display("** arc_fan_vertex_generator: FAILED **");
    end
    $finish;
  end
endmodule

@@ arc_fan_vertex_generator.f @@
sv/afv_pkg.sv
sv/afv_div.sv
sv/afv_cordic.sv
sv/arc_fan_vertex_generator.sv
bench/arc_fan_vertex_generator_test.sv
